/* rtl/core/streaming_pattern_matcher_defines.svh */
// Assertion macros used by the pattern matcher top level.
`ifndef STREAMING_PATTERN_MATCHER_DEFINES_SVH
`define STREAMING_PATTERN_MATCHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/spm_pkg.sv */
// Package with sizes, register codes and word types of the pattern matcher.
`timescale 1ns / 1ps
`default_nettype none

package spm_pkg;

    // Longest pattern the cell row can hold, and width of the position counter.
    localparam int PATTERN_MAX   = 32;
    localparam int POSITION_BITS = 32;

    // Width that holds an effective length from 1 to PATTERN_MAX.
    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // Configuration port and register file sizes.
    localparam int CFG_LEN_W     = 6;
    localparam int CFG_DATA_W    = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int PATTERN_WORDS = 4;
    localparam int WORD_BYTES    = 8;
    localparam int PATTERN_BYTES = PATTERN_WORDS * WORD_BYTES;
    localparam int PB_IDX_W      = $clog2(PATTERN_BYTES);
    localparam int SEL_W         = (LEN_W > PB_IDX_W) ? LEN_W : PB_IDX_W;

    localparam int MATCH_START_W = 32;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PATTERN_LENGTH = 3'd0,
        REG_PATTERN_WORD0  = 3'd1,
        REG_PATTERN_WORD1  = 3'd2,
        REG_PATTERN_WORD2  = 3'd3,
        REG_PATTERN_WORD3  = 3'd4
    } cfg_reg_e;

    // Input word.
    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } text_word_t;

    // Result word.
    typedef struct packed {
        logic                     match_found;
        logic [MATCH_START_W-1:0] match_start;
    } result_word_t;

    // Window entry handed from one cell to the next.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } cell_data_t;

    // Control broadcast to every cell.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/spm_cell.sv */
// One window cell: holds a text byte, passes it on and compares it with its pattern byte.
`timescale 1ns / 1ps
`default_nettype none

module spm_cell
    import spm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cell_ctrl_t ctrl,
    input  wire cell_data_t upstream,
    input  wire logic [7:0] pattern_byte,
    input  wire logic       active,
    output cell_data_t      downstream,
    output logic            hit
);

    cell_data_t entry_reg;
    cell_data_t entry_next;

    // The compare looks at the byte this cell takes on the coming shift,
    // so the result covers the window that includes the new word.
    assign hit = !active || (upstream.valid && (upstream.data == pattern_byte));

    // Shift in from the neighbor, or empty the cell at the end of a text.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.shift)
        begin
            if (ctrl.clear)
            begin
                entry_next = '0;
            end
            else
            begin
                entry_next = upstream;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign downstream = entry_reg;

endmodule

`default_nettype wire

/* rtl/core/spm_cfg.sv */
// Configuration registers and the per-cell pattern alignment derived from them.
`timescale 1ns / 1ps
`default_nettype none

module spm_cfg
    import spm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic [7:0]                  aligned [PATTERN_MAX],
    output logic [PATTERN_MAX-1:0]      active,
    output logic [LEN_W-1:0]            eff_len,
    output logic                        busy
);

    logic [CFG_LEN_W-1:0]   len_reg;
    logic [CFG_LEN_W-1:0]   len_next;
    logic [7:0]             pat_reg [PATTERN_BYTES];
    logic [7:0]             pat_next [PATTERN_BYTES];
    logic [7:0]             aligned_reg [PATTERN_MAX];
    logic [7:0]             aligned_next [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] active_reg;
    logic [PATTERN_MAX-1:0] active_next;
    logic [LEN_W-1:0]       eff_len_reg;
    logic [LEN_W-1:0]       eff_len_next;
    logic                   busy_reg;
    logic                   word_write;
    logic [1:0]             word_sel;

    // Decode the register index; unknown indexes are ignored.
    always_comb
    begin
        word_write = 1'b0;
        word_sel   = 2'd0;
        len_next   = len_reg;
        case (cfg_index)
            REG_PATTERN_LENGTH:
            begin
                if (cfg_write)
                begin
                    len_next = cfg_data[CFG_LEN_W-1:0];
                end
            end
            REG_PATTERN_WORD0:
            begin
                word_write = cfg_write;
                word_sel   = 2'd0;
            end
            REG_PATTERN_WORD1:
            begin
                word_write = cfg_write;
                word_sel   = 2'd1;
            end
            REG_PATTERN_WORD2:
            begin
                word_write = cfg_write;
                word_sel   = 2'd2;
            end
            REG_PATTERN_WORD3:
            begin
                word_write = cfg_write;
                word_sel   = 2'd3;
            end
            default:
            begin
                word_write = 1'b0;
            end
        endcase
    end

    // Unpack a written pattern word into its eight bytes.
    always_comb
    begin
        for (int w = 0; w < PATTERN_WORDS; w++)
        begin
            for (int b = 0; b < WORD_BYTES; b++)
            begin
                pat_next[w*WORD_BYTES + b] = pat_reg[w*WORD_BYTES + b];
                if (word_write && (word_sel == 2'(w)))
                begin
                    pat_next[w*WORD_BYTES + b] = cfg_data[8*b +: 8];
                end
            end
        end
    end

    // Effective length: zero acts as one, anything past the row acts as its size.
    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len_next = LEN_W'(1);
        end
        else if ({1'b0, len_reg} > (CFG_LEN_W+1)'(PATTERN_MAX))
        begin
            eff_len_next = LEN_W'(PATTERN_MAX);
        end
        else
        begin
            eff_len_next = LEN_W'(len_reg);
        end
    end

    // Cell k (newest byte at k = 0) checks pattern byte eff_len-1-k.
    always_comb
    begin
        logic [SEL_W-1:0] sel;
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            active_next[k]  = (SEL_W'(k) < SEL_W'(eff_len_next));
            sel             = SEL_W'(eff_len_next) - SEL_W'(1) - SEL_W'(k);
            aligned_next[k] = 8'd0;
            if (active_next[k] && (sel < SEL_W'(PATTERN_BYTES)))
            begin
                aligned_next[k] = pat_reg[sel[PB_IDX_W-1:0]];
            end
        end
    end

    // Register file, and the derived alignment registered from its contents.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= CFG_LEN_W'(1);
            eff_len_reg <= LEN_W'(1);
            active_reg  <= PATTERN_MAX'(1);
            busy_reg    <= 1'b0;
            for (int i = 0; i < PATTERN_BYTES; i++)
            begin
                pat_reg[i] <= 8'd0;
            end
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                aligned_reg[k] <= 8'd0;
            end
        end
        else
        begin
            len_reg     <= len_next;
            eff_len_reg <= eff_len_next;
            active_reg  <= active_next;
            busy_reg    <= cfg_write;
            for (int i = 0; i < PATTERN_BYTES; i++)
            begin
                pat_reg[i] <= pat_next[i];
            end
            for (int k = 0; k < PATTERN_MAX; k++)
            begin
                aligned_reg[k] <= aligned_next[k];
            end
        end
    end

    assign aligned = aligned_reg;
    assign active  = active_reg;
    assign eff_len = eff_len_reg;
    assign busy    = busy_reg;

endmodule

`default_nettype wire

/* rtl/core/streaming_pattern_matcher.sv */
// Top level of the streaming pattern matcher: cell row, position counter and result register.
//
//   Channel  | Handshake                  | Word
//   ---------+----------------------------+----------------------------------
//   text     | text_valid / text_stall    | text_byte, end_of_text
//   result   | result_valid / result_stall| match_found, match_start
//   config   | cfg_write                  | cfg_index, cfg_data
//
// One text word is taken every cycle unless the text channel is stalled; its result
// is in the output register in the cycle after acceptance. The cycle is set by the
// byte compare in every cell and the AND across the row of PATTERN_MAX cells.
// After reset the pattern is ready at once; there is no clearing pass.
// A configuration write stalls the text channel while cfg_write is high and while the
// busy register it sets is high, as the cell alignment is rebuilt. A stalled result holds the text side.
`timescale 1ns / 1ps
`default_nettype none

`include "streaming_pattern_matcher_defines.svh"

module streaming_pattern_matcher
    import spm_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_write,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   text_valid,
    output logic                        text_stall,
    input  wire text_word_t             text_word,
    output logic                        result_valid,
    input  wire logic                   result_stall,
    output result_word_t                result_word
);

    logic [7:0]             aligned [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] active;
    logic [LEN_W-1:0]       eff_len;
    logic                   cfg_busy;
    logic                   accept;
    cell_ctrl_t             ctrl;
    cell_data_t             chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0] hit_vec;
    logic [PATTERN_MAX-1:0] window_valid;
    logic                   match;

    logic [POSITION_BITS-1:0] bytes_seen_reg;
    logic [POSITION_BITS-1:0] bytes_seen_next;
    logic [POSITION_BITS-1:0] here_plus_one;
    logic [POSITION_BITS-1:0] start_full;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    result_word_t             result_word_reg;
    result_word_t             result_word_next;

    // Configuration registers and pattern alignment.
    spm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .aligned   (aligned),
        .active    (active),
        .eff_len   (eff_len),
        .busy      (cfg_busy)
    );

    // Handshake: take a word unless the result is held or the pattern is being rebuilt.
    assign text_stall = (result_valid_reg && result_stall) || cfg_write || cfg_busy;
    assign accept     = text_valid && !text_stall;

    assign ctrl.shift = accept;
    assign ctrl.clear = text_word.end_of_text;

    // The newest byte enters at the head of the row.
    assign chain[0].valid = 1'b1;
    assign chain[0].data  = text_word.text_byte;

    // Row of window cells, each handing its byte to the next.
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        spm_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .upstream     (chain[k]),
            .pattern_byte (aligned[k]),
            .active       (active[k]),
            .downstream   (chain[k+1]),
            .hit          (hit_vec[k])
        );
        assign window_valid[k] = chain[k+1].valid;
    end

    assign match = &hit_vec;

    // Position of this byte plus one, and the start of a match ending here.
    assign here_plus_one = bytes_seen_reg + POSITION_BITS'(1);
    assign start_full    = here_plus_one - POSITION_BITS'(eff_len);

    always_comb
    begin
        bytes_seen_next = bytes_seen_reg;
        if (accept)
        begin
            bytes_seen_next = text_word.end_of_text ? '0 : here_plus_one;
        end
    end

    // Output register: loads on accept, empties when the result side takes it.
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_word_next  = result_word_reg;
        if (accept)
        begin
            result_valid_next            = 1'b1;
            result_word_next.match_found = match;
            result_word_next.match_start = match ? MATCH_START_W'(start_full) : '0;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg   <= '0;
            result_valid_reg <= 1'b0;
            result_word_reg  <= '0;
        end
        else
        begin
            bytes_seen_reg   <= bytes_seen_next;
            result_valid_reg <= result_valid_next;
            result_word_reg  <= result_word_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_word  = result_word_reg;

    // Checks on the block's own logic.
    `SPM_ASSERT_NEXT(a_cfg_blocks_text, clk, rst_n, cfg_write, text_stall,
        "text accepted while the pattern alignment was stale")
    `SPM_ASSERT_NEXT(a_accept_gives_result, clk, rst_n, accept, result_valid,
        "accepted word produced no result")
    `SPM_ASSERT_NEXT(a_end_clears_window, clk, rst_n, accept && text_word.end_of_text,
        $countones(window_valid) == 0, "window not emptied at end of text")
    `SPM_ASSERT_NOW(a_miss_has_zero_start, clk, rst_n,
        result_valid && !result_word.match_found, result_word.match_start == '0,
        "result without a match carries a nonzero start")

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for the streaming pattern matcher: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb_top;
    import spm_pkg::*;

    localparam int RANDOM_PER_PHASE = 250;
    localparam int QUIET_LIMIT      = 4000;

    // Predicts the result word of every accepted text word and checks what the block returns.
    class match_scoreboard;
        result_word_t               pending_results[$];
        int unsigned                errors;
        logic [7:0]                 recent_text [PATTERN_MAX];
        logic [POSITION_BITS-1:0]   next_position;
        int unsigned                text_fill;
        logic [CFG_LEN_W-1:0]       length_reg;
        logic [CFG_DATA_W-1:0]      pattern_regs [PATTERN_WORDS];

        function new();
            errors        = 0;
            next_position = '0;
            text_fill     = 0;
            length_reg    = CFG_LEN_W'(1);
            foreach (recent_text[i])
                recent_text[i] = '0;
            foreach (pattern_regs[i])
                pattern_regs[i] = '0;
        endfunction

        // Mirror of a register write; unknown indexes leave everything as it is.
        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_PATTERN_LENGTH: length_reg = data[CFG_LEN_W-1:0];
                REG_PATTERN_WORD0, REG_PATTERN_WORD1, REG_PATTERN_WORD2, REG_PATTERN_WORD3:
                    pattern_regs[index - REG_PATTERN_WORD0] = data;
                default: ;
            endcase
        endfunction

        // Shift the word into the window and work out the match it completes, if any.
        function void note_text(text_word_t word);
            int unsigned              span;
            int unsigned              pidx;
            bit                       hit;
            logic [7:0]               want;
            logic [POSITION_BITS-1:0] start;
            result_word_t             outcome;
            span = (length_reg == 0) ? 1 :
                   (length_reg > PATTERN_MAX) ? PATTERN_MAX : int'(length_reg);
            for (int i = PATTERN_MAX - 1; i > 0; i--)
                recent_text[i] = recent_text[i-1];
            recent_text[0] = word.text_byte;
            if (text_fill < PATTERN_MAX)
                text_fill++;

            // The newest byte lines up with the last pattern byte.
            hit = (text_fill >= span);
            for (int k = 0; k < span; k++)
            begin
                pidx = span - 1 - k;
                want = (pidx >= PATTERN_BYTES) ? 8'h00 :
                       pattern_regs[pidx / WORD_BYTES][(pidx % WORD_BYTES) * 8 +: 8];
                if (recent_text[k] != want)
                    hit = 1'b0;
            end

            start = next_position + 1'b1 - POSITION_BITS'(span);
            outcome.match_found = hit;
            outcome.match_start = hit ? MATCH_START_W'(start) : '0;
            pending_results = {pending_results, outcome};
            next_position = next_position + 1'b1;

            // The last byte of a text clears the window and the position.
            if (word.end_of_text)
            begin
                foreach (recent_text[i])
                    recent_text[i] = '0;
                next_position = '0;
                text_fill     = 0;
            end
        endfunction

        // Compare one returned result word with the oldest prediction.
        function void check_result(result_word_t got);
            result_word_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none pending: expected nothing, actual found=%0b start=%0d",
                         $time, got.match_found, got.match_start);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.match_found !== want.match_found)
            begin
                $display("%0t: match_found mismatch: expected %0b, actual %0b",
                         $time, want.match_found, got.match_found);
                errors++;
            end
            if (got.match_start !== want.match_start)
            begin
                $display("%0t: match_start mismatch: expected %0d, actual %0d",
                         $time, want.match_start, got.match_start);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   text_valid;
    logic                   text_stall;
    text_word_t             text_word;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_word_t           result_word;

    match_scoreboard        match_checker;
    int unsigned            send_idle_pct = 14;
    int unsigned            stall_pct     = 56;
    int unsigned            random_sent   = 0;
    int unsigned            quiet_cycles  = 0;
    logic [7:0]             pattern [PATTERN_BYTES];
    logic [7:0]             alphabet [2];
    bit                     narrow_text;
    int unsigned            match_len;

    streaming_pattern_matcher DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_word    (text_word),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_word  (result_word)
    );

    always #4 clk = ~clk;

    // Receiver back-pressure, changed on the falling edge.
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < stall_pct);

    // Result monitor.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            match_checker.check_result(result_word);
    end

    // Watchdog on cycles with no word accepted on either channel.
    always @(posedge clk)
    begin
        if ((text_valid && !text_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Offer one text word, with random idle cycles ahead of it, and wait for acceptance.
    task automatic send_text(logic [7:0] data, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            text_valid <= 1'b0;
            @(negedge clk);
        end
        text_valid            <= 1'b1;
        text_word.text_byte   <= data;
        text_word.end_of_text <= last;
        do
            @(posedge clk);
        while (text_stall);
        match_checker.note_text(text_word);
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_idle();
        text_valid <= 1'b0;
        while (match_checker.pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
        @(negedge clk);
    endtask

    // One register write; the caller lowers cfg_write after the last one of a burst.
    task automatic write_reg_port(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        match_checker.write_reg(index, data);
        @(negedge clk);
    endtask

    // Load the length and all pattern words from the pattern array while the block is idle.
    task automatic write_pattern(logic [CFG_LEN_W-1:0] raw_len);
        logic [CFG_DATA_W-1:0] data;
        wait_idle();
        data = {$urandom, $urandom};
        data[CFG_LEN_W-1:0] = raw_len;
        write_reg_port(REG_PATTERN_LENGTH, data);
        for (int w = 0; w < PATTERN_WORDS; w++)
        begin
            for (int b = 0; b < WORD_BYTES; b++)
                data[b*8 +: 8] = pattern[w * WORD_BYTES + b];
            write_reg_port(CFG_INDEX_W'(REG_PATTERN_WORD0 + w), data);
        end
        // Now and then poke the indexes that have no register behind them.
        if ($urandom_range(3) == 0)
        begin
            for (int idx = REG_PATTERN_WORD3 + 1; idx < 2 ** CFG_INDEX_W; idx++)
                write_reg_port(CFG_INDEX_W'(idx), {$urandom, $urandom});
        end
        cfg_write <= 1'b0;
        match_len = (raw_len == 0) ? 1 :
                    (raw_len > PATTERN_MAX) ? PATTERN_MAX : int'(raw_len);
    endtask

    // Pick a new pattern: mostly short ones, often over a two-byte alphabet so that
    // overlapping occurrences show up.
    task automatic choose_pattern();
        int unsigned          pick;
        logic [CFG_LEN_W-1:0] raw_len;
        pick = $urandom_range(99);
        if (pick < 8)
            raw_len = ($urandom_range(1) == 0) ? '0 :
                      CFG_LEN_W'($urandom_range(PATTERN_MAX + 1, 2 ** CFG_LEN_W - 1));
        else if (pick < 70)
            raw_len = CFG_LEN_W'($urandom_range(1, 4));
        else if (pick < 90)
            raw_len = CFG_LEN_W'($urandom_range(5, 12));
        else
            raw_len = CFG_LEN_W'($urandom_range(13, PATTERN_MAX));
        narrow_text = ($urandom_range(99) < 60);
        alphabet[0] = 8'($urandom_range(255));
        alphabet[1] = 8'($urandom_range(255));
        foreach (pattern[k])
            pattern[k] = narrow_text ? alphabet[$urandom_range(1)] : 8'($urandom_range(255));
        write_pattern(raw_len);
    endtask

    // One text built from whole and broken copies of the pattern mixed with noise bytes.
    task automatic send_random_text();
        logic [7:0]  text_q[$];
        int unsigned target;
        int unsigned copy_len;
        bit          close_text;
        target     = ($urandom_range(9) == 0) ? $urandom_range(40, 90) : $urandom_range(1, 30);
        close_text = ($urandom_range(99) < 80);
        while (text_q.size() < target)
        begin
            if ($urandom_range(99) < 35)
            begin
                copy_len = ($urandom_range(99) < 25) ? $urandom_range(match_len) : match_len;
                for (int k = 0; k < copy_len; k++)
                    text_q = {text_q, pattern[k]};
            end
            else if (narrow_text)
                text_q = {text_q, alphabet[$urandom_range(1)]};
            else
                text_q = {text_q, 8'($urandom_range(255))};
        end
        foreach (text_q[i])
        begin
            send_text(text_q[i], close_text && (i == text_q.size() - 1));
            random_sent++;
        end
    endtask

    initial
    begin
        match_checker = new();
        rst_n      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        text_valid = 1'b0;
        text_word  = '0;
        foreach (pattern[k])
            pattern[k] = '0;
        match_len = 1;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: one zero byte, found wherever a zero arrives.
        send_text(8'h00, 1'b0);
        send_text(8'hFF, 1'b0);
        send_text(8'h00, 1'b1);

        // A zero length acts as one; pattern words all ones.
        foreach (pattern[k])
            pattern[k] = 8'hFF;
        write_pattern('0);
        send_text(8'hFF, 1'b0);
        send_text(8'hFF, 1'b1);

        // Overlapping occurrences, and no match across the end of a text.
        foreach (pattern[k])
            pattern[k] = 8'h00;
        pattern[0] = 8'h61;
        pattern[1] = 8'h62;
        pattern[2] = 8'h61;
        write_pattern(CFG_LEN_W'(3));
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b0);
        send_text(8'h61, 1'b1);
        send_text(8'h61, 1'b0);
        send_text(8'h62, 1'b1);
        send_text(8'h61, 1'b0);

        // An oversized length acts as the full window; a short text never matches it.
        foreach (pattern[k])
            pattern[k] = 8'h00;
        write_pattern(CFG_LEN_W'(2 ** CFG_LEN_W - 1));
        repeat (4) send_text(8'h00, 1'b0);

        // A write in the middle of a text keeps the bytes already in the window.
        write_pattern(CFG_LEN_W'(2));
        send_text(8'h00, 1'b1);

        // Random texts under three idling regimes.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 14;
                    stall_pct     = 56;
                end
                1:
                begin
                    send_idle_pct = 56;
                    stall_pct     = 14;
                end
                default:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
            endcase
            choose_pattern();
            while (random_sent < RANDOM_PER_PHASE * (phase + 1))
            begin
                if ($urandom_range(2) == 0)
                    choose_pattern();
                send_random_text();
            end
        end

        wait_idle();
        repeat (3) @(negedge clk);
        if (match_checker.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/spm_pkg.sv
rtl/core/spm_cell.sv
rtl/core/spm_cfg.sv
rtl/core/streaming_pattern_matcher.sv
tb/tb_top.sv
